[rtl/ervad_pkg.sv]
// Shared widths, configuration indexes and controller/datapath interface types.
package ervad_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int ENERGY_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int COEFF_BITS  = 16;
    localparam int RATIO_BITS  = 16;
    localparam int RATIO_FRAC  = 12;
    localparam int PROD_BITS   = ENERGY_BITS + COUNT_BITS;
    localparam int WIDE_BITS   = 2 * ENERGY_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_ENABLE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_COEFF  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENERGY_RATIO  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_SAMPLES  = 3'd3;

    localparam logic [COEFF_BITS-1:0] RST_FILTER_COEFF = 16'd2477;
    localparam logic [RATIO_BITS-1:0] RST_ENERGY_RATIO = 16'd2458;
    localparam logic [COUNT_BITS-1:0] RST_LAST_SAMPLES = 16'd16000;

    // Steps of the shared decision multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_TAIL_LEN,
        MUL_TOTAL_RATIO,
        MUL_LOW_LAST,
        MUL_HIGH_LAST
    } t_mul_step;

    typedef struct packed {
        logic      load;
        logic      accumulate;
        t_mul_step mul_step;
        logic      decide;
    } t_dp_cmd;

    typedef struct packed {
        logic window_end;
        logic too_short;
    } t_dp_status;

endpackage

[rtl/ervad_ctrl.sv]
// Sequencing state machine for sample accumulation and the window decision.
module ervad_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ervad_pkg::t_dp_status i_status,
    output ervad_pkg::t_dp_cmd    o_cmd
);
    import ervad_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ACC    = 7'b0000010,
        ST_MUL1   = 7'b0000100,
        ST_MUL2   = 7'b0001000,
        ST_MUL3   = 7'b0010000,
        ST_MUL4   = 7'b0100000,
        ST_DECIDE = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.load       = 1'b0;
        o_cmd.accumulate = 1'b0;
        o_cmd.mul_step   = MUL_NONE;
        o_cmd.decide     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.accumulate = 1'b1;
                if (i_status.window_end && !i_status.too_short) begin
                    n_state = ST_MUL1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL1: begin
                o_cmd.mul_step = MUL_TAIL_LEN;
                n_state        = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul_step = MUL_TOTAL_RATIO;
                n_state        = ST_MUL3;
            end
            ST_MUL3: begin
                o_cmd.mul_step = MUL_LOW_LAST;
                n_state        = ST_MUL4;
            end
            ST_MUL4: begin
                o_cmd.mul_step = MUL_HIGH_LAST;
                n_state        = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Busy through reset so nothing is taken before the state is known.
    assign busy = (r_state != ST_IDLE) || !i_rst_n;

endmodule

[rtl/ervad_datapath.sv]
// Filter, energy accumulators, configuration registers and decision arithmetic.
module ervad_datapath (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  ervad_pkg::t_dp_cmd                         i_cmd,
    output ervad_pkg::t_dp_status                      o_status,
    input  logic signed [ervad_pkg::SAMPLE_BITS-1:0]   i_sample,
    input  logic        [ervad_pkg::COUNT_BITS-1:0]    i_window_len,
    input  logic                                       i_cfg_we,
    input  logic        [ervad_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic        [ervad_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                                       o_valid,
    output logic                                       o_tail_quiet,
    output logic                                       o_status_bit
);
    import ervad_pkg::*;

    localparam int DIFF_BITS  = SAMPLE_BITS + 2;
    localparam int FPROD_BITS = DIFF_BITS + COEFF_BITS + 1;
    localparam int SHIFT_BITS = FPROD_BITS - COEFF_BITS;

    localparam logic signed [SHIFT_BITS-1:0] Y_MAX =
        SHIFT_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SHIFT_BITS-1:0] Y_MIN =
        SHIFT_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [FPROD_BITS-1:0] ROUND_HALF =
        FPROD_BITS'(64'sd1 <<< (COEFF_BITS - 1));

    // Configuration
    logic                  r_filter_enable;
    logic [COEFF_BITS-1:0] r_filter_coeff;
    logic [RATIO_BITS-1:0] r_energy_ratio;
    logic [COUNT_BITS-1:0] r_last_samples;

    // Window state
    logic        [COUNT_BITS-1:0]  r_index;
    logic        [COUNT_BITS-1:0]  r_len;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic        [ENERGY_BITS-1:0] r_total;
    logic        [ENERGY_BITS-1:0] r_tail;

    // Decision
    logic [PROD_BITS-1:0] r_part;
    logic [WIDE_BITS-1:0] r_lhs;
    logic [WIDE_BITS-1:0] r_rhs;

    logic r_valid;
    logic r_quiet;
    logic r_short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_enable <= 1'b1;
            r_filter_coeff  <= RST_FILTER_COEFF;
            r_energy_ratio  <= RST_ENERGY_RATIO;
            r_last_samples  <= RST_LAST_SAMPLES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FILTER_ENABLE: r_filter_enable <= i_cfg_data[0];
                CFG_FILTER_COEFF:  r_filter_coeff  <= COEFF_BITS'(i_cfg_data);
                CFG_ENERGY_RATIO:  r_energy_ratio  <= RATIO_BITS'(i_cfg_data);
                CFG_LAST_SAMPLES:  r_last_samples  <= COUNT_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // High-pass filter on the incoming sample: y = alpha * (y + x - xprev).
    logic signed [DIFF_BITS-1:0]  w_diff;
    logic signed [FPROD_BITS-1:0] w_fprod;
    logic signed [FPROD_BITS-1:0] w_fround;
    logic signed [SHIFT_BITS-1:0] w_fshift;
    logic signed [SAMPLE_BITS-1:0] w_filtered;
    logic signed [SAMPLE_BITS-1:0] w_y;

    assign w_diff = DIFF_BITS'(r_y) + DIFF_BITS'(i_sample) - DIFF_BITS'(r_prev);
    assign w_fprod = FPROD_BITS'(w_diff)
                   * $signed({{(FPROD_BITS-COEFF_BITS){1'b0}}, r_filter_coeff});
    assign w_fround = w_fprod + ROUND_HALF;
    assign w_fshift = w_fround[FPROD_BITS-1:COEFF_BITS];

    always_comb begin
        if (w_fshift > Y_MAX) begin
            w_filtered = Y_MAX[SAMPLE_BITS-1:0];
        end else if (w_fshift < Y_MIN) begin
            w_filtered = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            w_filtered = w_fshift[SAMPLE_BITS-1:0];
        end
    end

    // First sample of a window starts the recursion unfiltered.
    assign w_y = (r_index == '0 || !r_filter_enable) ? i_sample : w_filtered;

    // Accumulation of |y|
    logic [SAMPLE_BITS-1:0] w_mag;
    logic                   w_in_tail;
    logic [ENERGY_BITS-1:0] w_total_next;
    logic [ENERGY_BITS-1:0] w_tail_next;

    assign w_mag = r_y[SAMPLE_BITS-1] ? (~r_y + 1'b1) : r_y;
    assign w_in_tail = ({1'b0, r_index} + {1'b0, r_last_samples}) >= {1'b0, r_len};
    assign w_total_next = r_total + ENERGY_BITS'(w_mag);
    assign w_tail_next  = w_in_tail ? (r_tail + ENERGY_BITS'(w_mag)) : r_tail;

    assign o_status.window_end = r_index >= (r_len - 1'b1);
    assign o_status.too_short  = r_len <= r_last_samples;

    // Shared energy-by-count multiplier
    logic [ENERGY_BITS-1:0] w_mul_a;
    logic [COUNT_BITS-1:0]  w_mul_b;
    logic [PROD_BITS-1:0]   w_mul_p;

    always_comb begin
        w_mul_a = r_tail;
        w_mul_b = r_len;
        case (i_cmd.mul_step)
            MUL_TOTAL_RATIO: begin
                w_mul_a = r_total;
                w_mul_b = r_energy_ratio;
            end
            MUL_LOW_LAST: begin
                w_mul_a = r_part[ENERGY_BITS-1:0];
                w_mul_b = r_last_samples;
            end
            MUL_HIGH_LAST: begin
                w_mul_a = ENERGY_BITS'(r_part[PROD_BITS-1:ENERGY_BITS]);
                w_mul_b = r_last_samples;
            end
            default: ;
        endcase
    end

    assign w_mul_p = PROD_BITS'(w_mul_a) * PROD_BITS'(w_mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_prev  <= '0;
            r_y     <= '0;
            r_total <= '0;
            r_tail  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cmd.load) begin
                r_prev <= i_sample;
                r_y    <= w_y;
            end
            if (i_cmd.accumulate) begin
                r_total <= w_total_next;
                r_tail  <= w_tail_next;
                if (o_status.window_end) begin
                    r_index <= '0;
                    if (o_status.too_short) begin
                        r_total <= '0;
                        r_tail  <= '0;
                        r_valid <= 1'b1;
                    end
                end else begin
                    r_index <= r_index + 1'b1;
                end
            end
            if (i_cmd.decide) begin
                r_total <= '0;
                r_tail  <= '0;
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len <= (i_window_len == '0) ? COUNT_BITS'(1) : i_window_len;
        end
        case (i_cmd.mul_step)
            MUL_TAIL_LEN:    r_lhs <= WIDE_BITS'(w_mul_p) << RATIO_FRAC;
            MUL_TOTAL_RATIO: r_part <= w_mul_p;
            MUL_LOW_LAST:    r_rhs <= WIDE_BITS'(w_mul_p);
            MUL_HIGH_LAST:   r_rhs <= r_rhs + {w_mul_p[ENERGY_BITS-1:0], {ENERGY_BITS{1'b0}}};
            default: ;
        endcase
        if (i_cmd.accumulate && o_status.window_end && o_status.too_short) begin
            r_quiet <= 1'b0;
            r_short <= 1'b1;
        end
        if (i_cmd.decide) begin
            r_quiet <= !(r_lhs > r_rhs);
            r_short <= 1'b0;
        end
    end

    assign o_valid      = r_valid;
    assign o_tail_quiet = r_quiet;
    assign o_status_bit = r_short;

endmodule

[rtl/energy_ratio_voice_activity_detector.sv]
// Top level of the energy-ratio voice activity detector.
//
// Usage:
//   Samples are offered on i_sample with the window length on i_window_len
//   and taken at a rising edge with start high and busy low. Each sample is
//   high-pass filtered (when enabled), its magnitude is added to the whole-
//   window and (in the tail) tail energies; a window's last sample yields one
//   decision on o_tail_quiet / o_status, marked by o_valid for one cycle.
//   The receiver cannot stall; a result must be taken in its cycle.
// Sequencing:
//   Each taken sample holds busy while it is accumulated, so a new sample
//   is taken only once busy drops. A window's last sample then runs four
//   steps of the shared 32x16 energy multiplier plus a compare before its
//   result; a too-short window skips them and reports straight from the
//   accumulate step.
// Configuration:
//   Register writes transfer when i_cfg_valid and o_cfg_ready are high;
//   write only while the block is idle. Reset (synchronous, i_rst_n low)
//   restores register defaults, clears the window state and holds busy.
module energy_ratio_voice_activity_detector (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic signed [ervad_pkg::SAMPLE_BITS-1:0]   i_sample,
    input  logic        [ervad_pkg::COUNT_BITS-1:0]    i_window_len,
    output logic                                       o_valid,
    output logic                                       o_tail_quiet,
    output logic                                       o_status,
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic        [ervad_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic        [ervad_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import ervad_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Registers are always writable outside reset.
    assign o_cfg_ready = i_rst_n;

    ervad_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    ervad_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_sample     (i_sample),
        .i_window_len (i_window_len),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_tail_quiet (o_tail_quiet),
        .o_status_bit (o_status)
    );

endmodule
